[hdl/u64da_pkg.sv]
// shared constants and types for the decimal ascii converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package u64da_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int IN_WIDTH    = 64;
  localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W       = $clog2(DIGITS + 1);
  localparam int CHAR_W      = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

  typedef struct packed {
    logic             run;
    logic             done;
    logic [BCD_W-1:0] bcd;
  } dab_stat_t;

endpackage

`default_nettype wire

[hdl/u64da_dabble.sv]
// bit-serial shift-add-3 binary to bcd converter, one input bit per cycle
// depends on u64da_pkg
`timescale 1ns / 1ps
`default_nettype none

module u64da_dabble
  import u64da_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic [VALUE_WIDTH-1:0] bin_in,
  output dab_stat_t                   stat
);

  logic [VALUE_WIDTH-1:0] bin;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt;
  logic                   run;
  logic                   done;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
        cnt <= CNT_W'(VALUE_WIDTH);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin <= bin_in;
      bcd <= '0;
    end else if (run) begin
      bin <= {bin[VALUE_WIDTH-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_WIDTH-1]};
    end
  end

  assign stat.run  = run;
  assign stat.done = done;
  assign stat.bcd  = bcd;

endmodule

`default_nettype wire

[hdl/u64da_emit.sv]
// digit emitter: shifts bcd out one digit per cycle, drops leading zeros
// depends on u64da_pkg
`timescale 1ns / 1ps
`default_nettype none

module u64da_emit
  import u64da_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dab_stat_t         dab,
  output logic                   active,
  output logic                   strobe,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last
);

  logic [BCD_W-1:0] sreg;
  logic [IDX_W-1:0] idx;
  logic             seen;
  logic [3:0]       top;
  logic             final_dig;

  assign top       = sreg[BCD_W-1 -: 4];
  assign final_dig = (idx == IDX_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      idx    <= '0;
      seen   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (dab.done) begin
        active <= 1'b1;
        idx    <= IDX_W'(DIGITS);
        seen   <= 1'b0;
      end else if (active) begin
        idx <= idx - 1'b1;
        if (final_dig || top != 4'd0 || seen) begin
          strobe <= 1'b1;
          seen   <= 1'b1;
        end
        if (final_dig) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dab.done) begin
      sreg <= dab.bcd;
    end else if (active) begin
      sreg       <= {sreg[BCD_W-5:0], 4'd0};
      digit_char <= ASCII_ZERO + {2'b00, top};
      last       <= final_dig;
    end
  end

endmodule

`default_nettype wire

[hdl/u64_to_decimal_ascii.sv]
// unsigned 64-bit to decimal ascii converter, msd first, no leading zeros
// digit slots follow start being taken; slots that hold leading zeros give no strobe,
// so the final digit always sits on the ports in the last slot
// each value passes load, 64 shift-add-3 steps, hand-off, 20 digit slots; start is ignored while busy
// synchronous active-high reset clears all control; results cannot stall
// depends on u64da_pkg, u64da_dabble, u64da_emit
`timescale 1ns / 1ps
`default_nettype none

module u64_to_decimal_ascii
  import u64da_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [IN_WIDTH-1:0] value,
  output logic                     strobe,
  output logic [CHAR_W-1:0]        digit_char,
  output logic                     last
);

  dab_stat_t dab;
  logic      emit_active;
  logic      accept;

  assign accept = start && !busy;
  assign busy   = dab.run || dab.done || emit_active;

  u64da_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .bin_in (value[VALUE_WIDTH-1:0]),
    .stat   (dab)
  );

  u64da_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .dab        (dab),
    .active     (emit_active),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last       (last)
  );

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({dab.run, dab.done, emit_active}))
    else $error("converter and emitter overlap");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after accept");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (digit_char >= ASCII_ZERO && digit_char <= ASCII_NINE))
    else $error("digit out of range");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("word after final digit");

endmodule

`default_nettype wire

[tb/tb_u64_to_decimal_ascii.sv]
// self-checking testbench for u64_to_decimal_ascii: drives unsigned values and checks every
// emitted digit and its last flag against a digit queue built in the testbench
// depends on u64da_pkg and the u64_to_decimal_ascii rtl
`timescale 1ns / 1ps

module tb_u64_to_decimal_ascii;
  import u64da_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_VALUES = 120;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } digit_t;

  class digit_scoreboard;
    digit_t expected_q[$];
    int     errors = 0;

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    // decimal digits of one accepted word, msd first
    function void note_value(logic [IN_WIDTH-1:0] v);
      logic [IN_WIDTH-1:0] n;
      digit_t              msd_first[$];
      digit_t              d;
      n = '0;
      n[VALUE_WIDTH-1:0] = v[VALUE_WIDTH-1:0];
      do begin
        d.ch  = ASCII_ZERO + CHAR_W'(n % 10);
        d.fin = 1'b0;
        msd_first.push_front(d);
        n = n / 10;
      end while (n != 0);
      msd_first[msd_first.size()-1].fin = 1'b1;
      foreach (msd_first[k]) expected_q.push_back(msd_first[k]);
    endfunction

    task check_digit(logic [CHAR_W-1:0] ch, logic fin);
      digit_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("digit %0d last %b with nothing expected", ch, fin));
      end else begin
        want = expected_q.pop_front();
        if (ch !== want.ch)
          report_mismatch($sformatf("digit_char %0d, expected %0d", ch, want.ch));
        if (fin !== want.fin)
          report_mismatch($sformatf("last %b, expected %b (digit %0d)", fin, want.fin, want.ch));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [IN_WIDTH-1:0] value = '0;
  logic                busy;
  logic                strobe;
  logic [CHAR_W-1:0]   digit_char;
  logic                last;
  int                  cycles = 0;

  digit_scoreboard sb = new();

  u64_to_decimal_ascii i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_u64_to_decimal_ascii failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) sb.check_digit(digit_char, last);
  end

  // holds start high until the word is taken
  task automatic send_value(logic [IN_WIDTH-1:0] v);
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_value(v);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      value <= {$urandom, $urandom};
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_digits();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pow10(int e);
    logic [63:0] p;
    p = 64'd1;
    repeat (e) p = p * 10;
    return p;
  endfunction

  // random value with exactly nd decimal digits
  function automatic logic [63:0] value_of_length(int nd);
    logic [63:0] lo;
    logic [63:0] span;
    lo   = (nd == 1) ? 64'd0 : pow10(nd - 1);
    span = (nd == 20) ? (~64'd0 - lo) + 64'd1 : pow10(nd) - lo;
    return lo + ({$urandom, $urandom} % span);
  endfunction

  function automatic logic [63:0] random_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return value_of_length($urandom_range(1, 20));
    if (pick < 7) return {$urandom, $urandom} >> $urandom_range(0, 63);
    if (pick < 9) return {$urandom, $urandom};
    return 64'($urandom_range(0, 20));
  endfunction

  initial begin
    logic [63:0] directed[$];
    int          sent;
    int          burst;

    directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd1000000007,
                 64'd4294967295, 64'd4294967296, 64'd1234567890123456789,
                 64'd9999999999999999999, 64'd10000000000000000000,
                 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                 64'hffff_ffff_ffff_fffe, 64'hffff_ffff_ffff_ffff, 64'd90, 64'd101};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // back to back, then one with gaps
    foreach (directed[k]) send_value(directed[k]);
    idle_cycles(3);
    foreach (directed[k]) begin
      send_value(directed[k]);
      idle_cycles($urandom_range(0, 90));
    end
    drain_digits();

    sent = 0;
    while (sent < RANDOM_VALUES) begin
      burst = $urandom_range(1, 6);
      while (burst > 0 && sent < RANDOM_VALUES) begin
        send_value(random_value());
        sent++;
        burst--;
      end
      if (sent == RANDOM_VALUES / 2) drain_digits();
      else if ($urandom_range(0, 1) == 1) idle_cycles($urandom_range(1, 100));
    end

    drain_digits();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_u64_to_decimal_ascii passed");
    end else begin
      $display("tb_u64_to_decimal_ascii failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/u64da_pkg.sv
hdl/u64da_dabble.sv
hdl/u64da_emit.sv
hdl/u64_to_decimal_ascii.sv
tb/tb_u64_to_decimal_ascii.sv
